[src/tsdd_pkg.sv]
`default_nettype none

package tsdd_pkg;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    CMD_SET_NUMBER = 2'd0,
    CMD_SET_CHARS  = 2'd1,
    CMD_TICK       = 2'd2
  } cmd_e;

  // Operation kinds carried through the queue
  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  localparam int unsigned CODE_W  = 6;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned FRAME_W = SEG_W + 1;
  localparam int unsigned PHASE_W = 9;
  localparam int unsigned HOLD_W  = 8;

  localparam logic [CODE_W-1:0] SYM_BLANK    = 6'd10;
  localparam logic [CODE_W-1:0] SYM_MINUS    = 6'd11;
  localparam logic [CODE_W-1:0] SYM_LETTER_A = 6'd12;

  // Shift steps per digit: seven segments and the point
  localparam logic [PHASE_W-1:0] SHIFT_STEPS = 9'd8;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd5;

  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] right_code;
    logic              left_point;
    logic              right_point;
  } q_entry_t;

  // Segment pattern, bit 0 = segment a; codes above the table show blank
  function automatic logic [SEG_W-1:0] segments_of(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      6'd0:    seg = 7'h3F;
      6'd1:    seg = 7'h06;
      6'd2:    seg = 7'h5B;
      6'd3:    seg = 7'h4F;
      6'd4:    seg = 7'h66;
      6'd5:    seg = 7'h6D;
      6'd6:    seg = 7'h7D;
      6'd7:    seg = 7'h07;
      6'd8:    seg = 7'h7F;
      6'd9:    seg = 7'h6F;
      6'd10:   seg = 7'h00;
      6'd11:   seg = 7'h40;
      6'd12:   seg = 7'h77;
      6'd13:   seg = 7'h7C;
      6'd14:   seg = 7'h58;
      6'd15:   seg = 7'h5E;
      6'd16:   seg = 7'h79;
      6'd17:   seg = 7'h71;
      6'd18:   seg = 7'h7D;
      6'd19:   seg = 7'h76;
      6'd20:   seg = 7'h06;
      6'd21:   seg = 7'h0E;
      6'd22:   seg = 7'h76;
      6'd23:   seg = 7'h38;
      6'd24:   seg = 7'h54;
      6'd25:   seg = 7'h54;
      6'd26:   seg = 7'h5C;
      6'd27:   seg = 7'h73;
      6'd28:   seg = 7'h67;
      6'd29:   seg = 7'h50;
      6'd30:   seg = 7'h6D;
      6'd31:   seg = 7'h50;
      6'd32:   seg = 7'h1C;
      6'd33:   seg = 7'h1C;
      6'd34:   seg = 7'h1C;
      6'd35:   seg = 7'h76;
      6'd36:   seg = 7'h6E;
      6'd37:   seg = 7'h5B;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[src/two_digit_segment_display_driver.sv]
`default_nettype none

// Channel   Handshake                     Payload
// input     in_valid_i / in_stall_o       cmd_i, value_tenths_i, char_left_i, char_right_i
// output    out_valid_o / out_stall_i     serial_bit_o, shift_pulse_o, latch_pulse_o,
//                                         left_enable_o, right_enable_o
// config    hold_ticks_we_i               hold_ticks_i
//
// One input beat per clock sustained while in_stall_o is low; a tick beat is written
// to the queue when taken, then popped into the sequencer, whose step lands in the
// output register from which its output beat is offered.
// Set beats take one queue slot and one back-end pop but produce no output beat.
// Reset: display blank, left digit first, sequencer at its first shift step, hold 5.
// An output stall halts the back end; the front keeps taking beats until the
// QueueDepth-entry queue fills, then raises in_stall_o.

module two_digit_segment_display_driver #(
  parameter int unsigned QueueDepth = 2
) (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  // config
  input  var logic               hold_ticks_we_i,
  input  var logic [7:0]         hold_ticks_i,
  // input channel
  input  var logic               in_valid_i,
  output logic                   in_stall_o,
  input  var logic [1:0]         cmd_i,
  input  var logic signed [10:0] value_tenths_i,
  input  var logic [7:0]         char_left_i,
  input  var logic [7:0]         char_right_i,
  // output channel
  output logic                   out_valid_o,
  input  var logic               out_stall_i,
  output logic                   serial_bit_o,
  output logic                   shift_pulse_o,
  output logic                   latch_pulse_o,
  output logic                   left_enable_o,
  output logic                   right_enable_o
);

  tsdd_pkg::q_entry_t front_entry;
  tsdd_pkg::q_entry_t queue_entry;
  logic               front_push;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic               in_take;

  // Front: classify and format the beat into display codes
  tsdd_front u_front (
    .cmd_i          (cmd_i),
    .value_tenths_i (value_tenths_i),
    .char_left_i    (char_left_i),
    .char_right_i   (char_right_i),
    .entry_o        (front_entry),
    .push_o         (front_push)
  );

  assign in_stall_o = q_full;
  assign in_take    = in_valid_i && !q_full;

  // Short in-order queue: sets and ticks must keep their order
  tsdd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_take && front_push),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .pop_entry_o  (queue_entry)
  );

  // Back: display registers, refresh sequencer and output register
  tsdd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hold_ticks_we_i (hold_ticks_we_i),
    .hold_ticks_i    (hold_ticks_i),
    .q_empty_i       (q_empty),
    .q_entry_i       (queue_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .serial_bit_o    (serial_bit_o),
    .shift_pulse_o   (shift_pulse_o),
    .latch_pulse_o   (latch_pulse_o),
    .left_enable_o   (left_enable_o),
    .right_enable_o  (right_enable_o)
  );

endmodule

`default_nettype wire

[src/tsdd_front.sv]
`default_nettype none

module tsdd_front (
  input  var logic [1:0]         cmd_i,
  input  var logic signed [10:0] value_tenths_i,
  input  var logic [7:0]         char_left_i,
  input  var logic [7:0]         char_right_i,
  output tsdd_pkg::q_entry_t     entry_o,
  output logic                   push_o
);

  function automatic logic [tsdd_pkg::CODE_W:0] map_char(input logic [7:0] c);
    logic [tsdd_pkg::CODE_W-1:0] code;
    logic                        pt;
    logic [7:0]                  ofs;
    ofs  = c - 8'd97;
    pt   = 1'b0;
    code = tsdd_pkg::SYM_BLANK;
    if (c >= 8'd97 && c <= 8'd122) begin
      code = tsdd_pkg::SYM_LETTER_A + ofs[tsdd_pkg::CODE_W-1:0];
    end else if (c == 8'd46 || c == 8'd44) begin
      pt = 1'b1;
    end
    return {code, pt};
  endfunction

  logic                          neg;
  logic [10:0]                   mag;
  logic [9:0]                    m;
  logic [15:0]                   prod_h;
  logic [17:0]                   prod_t;
  logic [3:0]                    hundreds;
  logic [6:0]                    q;
  logic [9:0]                    units_w;
  logic [9:0]                    tenths_w;
  logic [3:0]                    units;
  logic [3:0]                    tenths;
  logic                          in_big;
  logic                          in_neg_tens;
  logic                          in_neg_unit;
  logic                          in_small;
  logic [tsdd_pkg::CODE_W:0]     map_l;
  logic [tsdd_pkg::CODE_W:0]     map_r;
  tsdd_pkg::q_entry_t            num_e;

  // Magnitude digits by reciprocal multiplication (exact for 0..999)
  assign neg      = value_tenths_i[10];
  assign mag      = neg ? (~value_tenths_i + 11'd1) : value_tenths_i;
  assign m        = mag[9:0];
  assign prod_h   = 16'(m) * 16'd41;
  assign prod_t   = 18'(m) * 18'd205;
  assign hundreds = prod_h[15:12];
  assign q        = prod_t[17:11];
  assign units_w  = 10'(q) - 10'(hundreds) * 10'd10;
  assign tenths_w = m - 10'(q) * 10'd10;
  assign units    = units_w[3:0];
  assign tenths   = tenths_w[3:0];

  assign in_big      = (value_tenths_i >= 11'sd100) && (value_tenths_i <= 11'sd999);
  assign in_neg_tens = (value_tenths_i >= -11'sd99) && (value_tenths_i <= -11'sd10);
  assign in_neg_unit = (value_tenths_i >= -11'sd9) && (value_tenths_i <= -11'sd1);
  assign in_small    = (value_tenths_i >= 11'sd0) && (value_tenths_i <= 11'sd99);

  always_comb begin
    num_e             = '0;
    num_e.op          = tsdd_pkg::OP_SET;
    num_e.left_code   = tsdd_pkg::SYM_BLANK;
    num_e.right_code  = tsdd_pkg::SYM_BLANK;
    num_e.left_point  = 1'b0;
    num_e.right_point = 1'b0;
    if (in_big) begin
      num_e.left_code  = 6'(hundreds);
      num_e.right_code = 6'(units);
    end else if (in_neg_tens) begin
      num_e.left_code  = tsdd_pkg::SYM_MINUS;
      num_e.right_code = 6'(q);
    end else if (in_neg_unit) begin
      num_e.left_code  = tsdd_pkg::SYM_MINUS;
      num_e.right_code = 6'(m);
      num_e.left_point = 1'b1;
    end else if (in_small) begin
      if (tenths != 4'd0) begin
        num_e.left_code  = 6'(q);
        num_e.right_code = 6'(tenths);
        num_e.left_point = 1'b1;
      end else begin
        num_e.right_code = 6'(q);
      end
    end
  end

  assign map_l = map_char(char_left_i);
  assign map_r = map_char(char_right_i);

  always_comb begin
    entry_o = num_e;
    push_o  = 1'b1;
    unique case (cmd_i)
      tsdd_pkg::CMD_SET_NUMBER: entry_o = num_e;
      tsdd_pkg::CMD_SET_CHARS: begin
        entry_o.op          = tsdd_pkg::OP_SET;
        entry_o.left_code   = map_l[tsdd_pkg::CODE_W:1];
        entry_o.left_point  = map_l[0];
        entry_o.right_code  = map_r[tsdd_pkg::CODE_W:1];
        entry_o.right_point = map_r[0];
      end
      tsdd_pkg::CMD_TICK: entry_o.op = tsdd_pkg::OP_TICK;
      default: push_o = 1'b0;  // unused command: dropped
    endcase
  end

endmodule

`default_nettype wire

[src/tsdd_queue.sv]
`default_nettype none

module tsdd_queue #(
  parameter int unsigned Depth = 2
) (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               push_i,
  input  var tsdd_pkg::q_entry_t push_entry_i,
  output logic                   full_o,
  input  var logic               pop_i,
  output logic                   empty_o,
  output tsdd_pkg::q_entry_t     pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tsdd_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o      = (count_q == FullCnt);
  assign empty_o     = (count_q == '0);
  assign pop_entry_o = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[src/tsdd_back.sv]
`default_nettype none

module tsdd_back (
  input  var logic                         clk_i,
  input  var logic                         rst_ni,
  input  var logic                         hold_ticks_we_i,
  input  var logic [tsdd_pkg::HOLD_W-1:0]  hold_ticks_i,
  input  var logic                         q_empty_i,
  input  var tsdd_pkg::q_entry_t           q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  var logic                         out_stall_i,
  output logic                             serial_bit_o,
  output logic                             shift_pulse_o,
  output logic                             latch_pulse_o,
  output logic                             left_enable_o,
  output logic                             right_enable_o
);

  logic [tsdd_pkg::HOLD_W-1:0]  hold_q;
  logic [tsdd_pkg::CODE_W-1:0]  left_code_q, right_code_q;
  logic                         left_point_q, right_point_q;
  logic                         active_q;
  logic [tsdd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [tsdd_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic                         out_valid_q;
  logic                         ser_q, shift_q, latch_q, len_q, ren_q;

  logic [tsdd_pkg::FRAME_W-1:0] cur_frame;
  logic [tsdd_pkg::FRAME_W-1:0] use_frame;
  logic [tsdd_pkg::PHASE_W-1:0] end_phase;
  logic                         is_shift, is_latch, at_end;
  logic                         tick_pop, set_pop;
  logic                         ser_d;
  logic                         active_d;

  // Pop whenever the output beat slot is free or being taken
  assign q_pop_o  = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign tick_pop = q_pop_o && (q_entry_i.op == tsdd_pkg::OP_TICK);
  assign set_pop  = q_pop_o && (q_entry_i.op == tsdd_pkg::OP_SET);

  assign cur_frame = active_q
                   ? {right_point_q, tsdd_pkg::segments_of(right_code_q)}
                   : {left_point_q, tsdd_pkg::segments_of(left_code_q)};
  assign use_frame = (phase_q == '0) ? cur_frame : frame_q;
  assign is_shift  = phase_q < tsdd_pkg::SHIFT_STEPS;
  assign is_latch  = phase_q == tsdd_pkg::SHIFT_STEPS;
  assign end_phase = tsdd_pkg::SHIFT_STEPS + tsdd_pkg::PHASE_W'(hold_q);
  assign at_end    = phase_q >= end_phase;
  assign ser_d     = is_shift && use_frame[phase_q[2:0]];

  always_comb begin
    frame_d  = use_frame;
    phase_d  = phase_q + tsdd_pkg::PHASE_W'(1);
    active_d = active_q;
    if (at_end) begin
      phase_d  = '0;
      active_d = !active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q        <= tsdd_pkg::HOLD_RESET;
      left_code_q   <= tsdd_pkg::SYM_BLANK;
      right_code_q  <= tsdd_pkg::SYM_BLANK;
      left_point_q  <= 1'b0;
      right_point_q <= 1'b0;
      active_q      <= 1'b0;
      phase_q       <= '0;
      frame_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (hold_ticks_we_i) begin
        hold_q <= hold_ticks_i;
      end
      if (set_pop) begin
        left_code_q   <= q_entry_i.left_code;
        right_code_q  <= q_entry_i.right_code;
        left_point_q  <= q_entry_i.left_point;
        right_point_q <= q_entry_i.right_point;
      end
      if (tick_pop) begin
        frame_q  <= frame_d;
        phase_q  <= phase_d;
        active_q <= active_d;
      end
      if (tick_pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat payload; holds while stalled since no tick pops then
  always_ff @(posedge clk_i) begin
    if (tick_pop) begin
      ser_q   <= ser_d;
      shift_q <= is_shift;
      latch_q <= is_latch;
      len_q   <= !is_shift && !is_latch && !active_q;
      ren_q   <= !is_shift && !is_latch && active_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign serial_bit_o   = ser_q;
  assign shift_pulse_o  = shift_q;
  assign latch_pulse_o  = latch_q;
  assign left_enable_o  = len_q;
  assign right_enable_o = ren_q;

endmodule

`default_nettype wire
